>>> hdl/anp_pkg.sv
// shared types, constants and character codes for the ascii number parser
package anp_pkg;

	localparam int ANP_VALUE_BITS = 32;
	localparam int ANP_OUT_BITS   = 32;
	localparam int ANP_CHAR_BITS  = 8;

	localparam logic [ANP_CHAR_BITS-1:0] CH_LOWER_X = 8'h78;
	localparam logic [ANP_CHAR_BITS-1:0] CH_UPPER_X = 8'h58;
	localparam logic [ANP_CHAR_BITS-1:0] CH_MINUS   = 8'h2d;
	localparam logic [ANP_CHAR_BITS-1:0] CH_PLUS    = 8'h2b;
	localparam logic [ANP_CHAR_BITS-1:0] CH_ZERO    = 8'h30;
	localparam logic [ANP_CHAR_BITS-1:0] CH_NINE    = 8'h39;
	localparam logic [ANP_CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
	localparam logic [ANP_CHAR_BITS-1:0] CH_LOWER_F = 8'h66;
	localparam logic [ANP_CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
	localparam logic [ANP_CHAR_BITS-1:0] CH_UPPER_F = 8'h46;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_ZERO   = 6'b000010,
		PH_DSIGN  = 6'b000100,
		PH_DDIG   = 6'b001000,
		PH_HSTART = 6'b010000,
		PH_HDIG   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic       is_dec;
		logic       is_hex;
		logic       is_zero;
		logic       is_x;
		logic       is_sign;
		logic       is_minus;
		logic [3:0] digit;
	} char_class_t;

	typedef struct packed {
		logic                    fire;
		logic [ANP_OUT_BITS-1:0] value;
		logic                    was_hex;
	} result_t;

endpackage

>>> hdl/ascii_number_parser_top.sv
// top level: input register, parse core and result register
// Streaming ASCII integer parser. One character word is taken per cycle
// (in_valid/in_ready); each is registered, then classified and folded into
// the accumulator, and a terminating character loads a result
// word (value, stop_char, was_hex) into the output register. Sustained rate is
// one character per cycle while out_ready is high; an accepted terminating
// character passes the input register, then sets out_valid in the output
// register. The input register holds while a result waits with out_ready low.
module ascii_number_parser_top import anp_pkg::*; #(
	parameter int VALUE_BITS = ANP_VALUE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ANP_CHAR_BITS-1:0]       char_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [ANP_OUT_BITS-1:0] value,
	output logic [ANP_CHAR_BITS-1:0]       stop_char,
	output logic                           was_hex
);

	logic                     valid_s1;
	logic [ANP_CHAR_BITS-1:0] char_s1;
	logic                     adv;
	char_class_t              cls;
	result_t                  res;

	logic                     out_valid_q;
	logic [ANP_OUT_BITS-1:0]  value_q;
	logic [ANP_CHAR_BITS-1:0] stop_char_q;
	logic                     was_hex_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	anp_classify u_classify (
		.char_in (char_s1),
		.cls     (cls)
	);

	anp_core #(
		.VALUE_BITS (VALUE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cls    (cls),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.fire) begin
			value_q     <= res.value;
			stop_char_q <= char_s1;
			was_hex_q   <= res.was_hex;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = signed'(value_q);
	assign stop_char = stop_char_q;
	assign was_hex   = was_hex_q;

endmodule

>>> hdl/anp_classify.sv
// character decode: digit classes, digit value, prefix and sign detection
module anp_classify import anp_pkg::*; (
	input  logic [ANP_CHAR_BITS-1:0] char_in,
	output char_class_t              cls
);

	logic is_num;
	logic is_low;
	logic is_up;

	always_comb begin
		is_num = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
		is_low = (char_in >= CH_LOWER_A) && (char_in <= CH_LOWER_F);
		is_up  = (char_in >= CH_UPPER_A) && (char_in <= CH_UPPER_F);

		cls.is_dec   = is_num;
		cls.is_hex   = is_num || is_low || is_up;
		cls.is_zero  = (char_in == CH_ZERO);
		cls.is_x     = (char_in == CH_LOWER_X) || (char_in == CH_UPPER_X);
		cls.is_sign  = (char_in == CH_MINUS) || (char_in == CH_PLUS);
		cls.is_minus = (char_in == CH_MINUS);

		if (is_low) begin
			cls.digit = 4'(char_in - CH_LOWER_A + 8'd10);
		end else if (is_up) begin
			cls.digit = 4'(char_in - CH_UPPER_A + 8'd10);
		end else begin
			cls.digit = 4'(char_in - CH_ZERO);
		end
	end

endmodule

>>> hdl/anp_core.sv
// parse state, accumulator update and result forming for one character
module anp_core import anp_pkg::*; #(
	parameter int VALUE_BITS = ANP_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  char_class_t cls,
	output result_t     res
);

	phase_t                  phase_q;
	phase_t                  phase_n;
	logic [VALUE_BITS-1:0]   acc_q;
	logic [VALUE_BITS-1:0]   acc_n;
	logic                    neg_q;
	logic                    neg_n;
	logic [VALUE_BITS-1:0]   mul10;
	logic [VALUE_BITS-1:0]   mul16;
	logic [VALUE_BITS-1:0]   dig_ext;
	logic [VALUE_BITS-1:0]   fin_acc;
	logic                    fin_neg;
	logic [VALUE_BITS-1:0]   signed_val;

	always_comb begin
		dig_ext = VALUE_BITS'(cls.digit);
		mul10   = (acc_q << 3) + (acc_q << 1) + dig_ext;
		mul16   = (acc_q << 4) + dig_ext;

		phase_n     = phase_q;
		acc_n       = acc_q;
		neg_n       = neg_q;
		fin_acc     = acc_q;
		fin_neg     = neg_q;
		res.fire    = 1'b0;
		res.was_hex = 1'b0;

		unique case (phase_q)
			PH_ZERO: begin
				if (cls.is_x) begin
					phase_n = PH_HSTART;
				end else if (cls.is_dec) begin
					acc_n   = mul10;
					phase_n = PH_DDIG;
				end else begin
					res.fire = 1'b1;
				end
			end
			PH_DSIGN, PH_DDIG: begin
				if (cls.is_dec) begin
					acc_n   = mul10;
					phase_n = PH_DDIG;
				end else begin
					res.fire = 1'b1;
				end
			end
			PH_HSTART: begin
				if (cls.is_sign) begin
					neg_n   = cls.is_minus;
					phase_n = PH_HDIG;
				end else if (cls.is_hex) begin
					acc_n   = mul16;
					phase_n = PH_HDIG;
				end else begin
					res.fire    = 1'b1;
					res.was_hex = 1'b1;
				end
			end
			PH_HDIG: begin
				if (cls.is_hex) begin
					acc_n = mul16;
				end else begin
					res.fire    = 1'b1;
					res.was_hex = 1'b1;
				end
			end
			default: begin
				acc_n   = '0;
				neg_n   = 1'b0;
				fin_acc = '0;
				fin_neg = 1'b0;
				if (cls.is_sign) begin
					neg_n   = cls.is_minus;
					phase_n = PH_DSIGN;
				end else if (cls.is_zero) begin
					phase_n = PH_ZERO;
				end else if (cls.is_dec) begin
					acc_n   = dig_ext;
					phase_n = PH_DDIG;
				end else begin
					res.fire = 1'b1;
				end
			end
		endcase

		if (res.fire) begin
			phase_n = PH_IDLE;
			acc_n   = '0;
			neg_n   = 1'b0;
		end

		signed_val = fin_neg ? (~fin_acc + 1'b1) : fin_acc;
		res.value  = ANP_OUT_BITS'(signed'(signed_val));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
		end
	end

endmodule

>>> bench/testbench.sv
// self-checking testbench for the streaming ascii number parser
module testbench import anp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DIRECTED_ROWS = 25;

	typedef struct {
		logic signed [ANP_OUT_BITS-1:0] value;
		logic [ANP_CHAR_BITS-1:0]       stop_char;
		logic                           was_hex;
	} number_t;

	typedef struct {
		logic [ANP_CHAR_BITS-1:0]       ch;
		bit                             typed;
		logic signed [ANP_OUT_BITS-1:0] value;
		logic [ANP_CHAR_BITS-1:0]       stop_char;
		logic                           was_hex;
	} char_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [ANP_CHAR_BITS-1:0]       char_in = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic signed [ANP_OUT_BITS-1:0] value;
	logic [ANP_CHAR_BITS-1:0]       stop_char;
	logic                           was_hex;

	phase_t                    parse_phase = PH_IDLE;
	logic [ANP_VALUE_BITS-1:0] parse_acc = '0;
	bit                        parse_neg = 1'b0;

	number_t   pending_numbers[$];
	number_t   no_number = '{value: '0, stop_char: '0, was_hex: 1'b0};
	char_row_t directed_rows[DIRECTED_ROWS];
	int        mismatch_count = 0;
	int        sent_chars = 0;
	int        cycle_count = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	int        hold_req = 0;
	int        hold_ack = 0;
	int        hold_left = 0;

	ascii_number_parser_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_in   (char_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.stop_char (stop_char),
		.was_hex   (was_hex)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int dec_digit(input logic [ANP_CHAR_BITS-1:0] ch);
		if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
		return -1;
	endfunction

	function automatic int hex_digit(input logic [ANP_CHAR_BITS-1:0] ch);
		if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
		if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) return int'(ch - CH_LOWER_A) + 10;
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) return int'(ch - CH_UPPER_A) + 10;
		return -1;
	endfunction

	// advances the parser state by one character, returns 1 when a number ends
	function automatic bit parse_char(input logic [ANP_CHAR_BITS-1:0] ch, output number_t res);
		int                        dd;
		int                        hd;
		bit                        done;
		bit                        hex;
		bit                        is_sign;
		logic [ANP_VALUE_BITS-1:0] mag;
		dd = dec_digit(ch);
		hd = hex_digit(ch);
		done = 1'b0;
		hex = 1'b0;
		is_sign = (ch == CH_MINUS) || (ch == CH_PLUS);
		res = no_number;
		case (parse_phase)
			PH_ZERO: begin
				if (ch == CH_LOWER_X || ch == CH_UPPER_X) begin
					parse_phase = PH_HSTART;
				end else if (dd >= 0) begin
					parse_acc = parse_acc * 10 + ANP_VALUE_BITS'(dd);
					parse_phase = PH_DDIG;
				end else begin
					done = 1'b1;
				end
			end
			PH_DSIGN, PH_DDIG: begin
				if (dd >= 0) begin
					parse_acc = parse_acc * 10 + ANP_VALUE_BITS'(dd);
					parse_phase = PH_DDIG;
				end else begin
					done = 1'b1;
				end
			end
			PH_HSTART: begin
				hex = 1'b1;
				if (is_sign) begin
					parse_neg = (ch == CH_MINUS);
					parse_phase = PH_HDIG;
				end else if (hd >= 0) begin
					parse_acc = parse_acc * 16 + ANP_VALUE_BITS'(hd);
					parse_phase = PH_HDIG;
				end else begin
					done = 1'b1;
				end
			end
			PH_HDIG: begin
				hex = 1'b1;
				if (hd >= 0) begin
					parse_acc = parse_acc * 16 + ANP_VALUE_BITS'(hd);
				end else begin
					done = 1'b1;
				end
			end
			default: begin
				parse_acc = '0;
				parse_neg = 1'b0;
				if (is_sign) begin
					parse_neg = (ch == CH_MINUS);
					parse_phase = PH_DSIGN;
				end else if (ch == CH_ZERO) begin
					parse_phase = PH_ZERO;
				end else if (dd >= 0) begin
					parse_acc = ANP_VALUE_BITS'(dd);
					parse_phase = PH_DDIG;
				end else begin
					done = 1'b1;
				end
			end
		endcase
		if (done) begin
			mag = parse_neg ? -parse_acc : parse_acc;
			res.value = ANP_OUT_BITS'(signed'(mag));
			res.stop_char = ch;
			res.was_hex = hex;
			parse_phase = PH_IDLE;
			parse_acc = '0;
			parse_neg = 1'b0;
		end
		return done;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		mismatch_count++;
	endtask

	task automatic send_char(input logic [ANP_CHAR_BITS-1:0] ch, input bit typed,
			input number_t typed_res);
		number_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= ch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_chars++;
		if (parse_char(ch, predicted))
			pending_numbers.push_back(typed ? typed_res : predicted);
	endtask

	function automatic logic [ANP_CHAR_BITS-1:0] pick_end_char();
		string enders;
		enders = " ,;\n+-xX.";
		if ($urandom_range(1)) return ANP_CHAR_BITS'($urandom_range(255));
		if ($urandom_range(9) == 0) return '0;
		return enders[$urandom_range(enders.len() - 1)];
	endfunction

	task automatic send_number();
		string hexset;
		int    kind;
		int    n;
		hexset = "0123456789abcdefABCDEF";
		kind = $urandom_range(99);
		if (kind < 12) begin
			send_char(ANP_CHAR_BITS'($urandom_range(255)), 1'b0, no_number);
			return;
		end
		if (kind < 55) begin
			case ($urandom_range(2))
				1: send_char(CH_MINUS, 1'b0, no_number);
				2: send_char(CH_PLUS, 1'b0, no_number);
				default: ;
			endcase
			n = ($urandom_range(7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 10);
			repeat (n) send_char(CH_ZERO + ANP_CHAR_BITS'($urandom_range(9)), 1'b0, no_number);
		end else if (kind < 92) begin
			send_char(CH_ZERO, 1'b0, no_number);
			send_char($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X, 1'b0, no_number);
			case ($urandom_range(3))
				1: send_char(CH_MINUS, 1'b0, no_number);
				2: send_char(CH_PLUS, 1'b0, no_number);
				default: ;
			endcase
			n = ($urandom_range(5) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 8);
			repeat (n) send_char(hexset[$urandom_range(hexset.len() - 1)], 1'b0, no_number);
		end else begin
			// broken prefixes: lone sign, sign before 0x
			send_char($urandom_range(1) ? CH_MINUS : CH_PLUS, 1'b0, no_number);
			if ($urandom_range(1)) begin
				send_char(CH_ZERO, 1'b0, no_number);
				send_char($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X, 1'b0, no_number);
			end
		end
		send_char(pick_end_char(), 1'b0, no_number);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= LONG_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		number_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_numbers.size() == 0) begin
				report_mismatch("unexpected word, value", value, '0);
			end else begin
				want = pending_numbers.pop_front();
				if (value !== want.value) report_mismatch("value", value, want.value);
				if (stop_char !== want.stop_char)
					report_mismatch("stop_char", 32'(stop_char), 32'(want.stop_char));
				if (was_hex !== want.was_hex)
					report_mismatch("was_hex", 32'(was_hex), 32'(want.was_hex));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ascii_number_parser_top regression: fail");
			$finish;
		end
	end

	initial begin
		directed_rows = '{
			'{"!",   1'b1, 32'sd0, "!",   1'b0},
			'{8'h00, 1'b1, 32'sd0, 8'h00, 1'b0},
			'{8'hff, 1'b1, 32'sd0, 8'hff, 1'b0},
			'{"-",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"9",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{" ",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"0",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"x",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"g",   1'b1, 32'sd0, "g",   1'b1},
			'{"-",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"0",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"x",   1'b1, 32'sd0, "x",   1'b0},
			'{"0",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"X",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"-",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"F",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"a",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"+",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"+",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"-",   1'b1, 32'sd0, "-",   1'b0},
			'{"0",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"7",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{".",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{"0",   1'b0, 32'sd0, 8'h00, 1'b0},
			'{8'h80, 1'b1, 32'sd0, 8'h80, 1'b0}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 18;
		rx_idle_pct = 84;
		foreach (directed_rows[i])
			send_char(directed_rows[i].ch, directed_rows[i].typed,
				'{value: directed_rows[i].value, stop_char: directed_rows[i].stop_char,
				  was_hex: directed_rows[i].was_hex});
		while (sent_chars < 400) send_number();

		tx_idle_pct = 84;
		rx_idle_pct = 18;
		while (sent_chars < 780) send_number();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req++;
		while (sent_chars < 1150) send_number();

		in_valid <= 1'b0;
		while (pending_numbers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ascii_number_parser_top regression: pass");
		end else begin
			$display("ascii_number_parser_top regression: fail");
		end
		$finish;
	end

endmodule
